>>> rtl/smr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multichannel speed ramp.
// Used by every module of the block; depends on nothing else.
package smr_pkg;

  localparam int DUTY_W   = 8;
  localparam int TIME_W   = 32;
  localparam int LEN_W    = 16;
  localparam int PCT_W    = 8;
  localparam int CHAN_W   = 2;
  localparam int CFG_W    = 3;
  localparam int PROD_W   = LEN_W + DUTY_W;
  localparam int Q_W      = DUTY_W;
  localparam int QCNT_W   = $clog2(Q_W);

  localparam logic [PCT_W-1:0] PCT_MAX    = PCT_W'(100);
  localparam int               DUTY_MAX   = 255;
  localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(4);

  // 2^19 / 100 rounded up; exact floor for every dividend up to 100 * 255.
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);
  localparam int SCALE_W     = 15;
  localparam int SCALED_W    = SCALE_W + RECIP_W;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CHAN_W-1:0] channel;
    logic [PCT_W-1:0]  speed_percent;
    logic [LEN_W-1:0]  ramp_ms;
    logic [TIME_W-1:0] now_ms;
  } smr_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [DUTY_W-1:0] duty;
    logic              last;
  } smr_res_t;

  // Clamp a percentage to 100 and scale it to 0..255, truncating.
  function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0]    p;
    logic [SCALE_W-1:0]  x;
    logic [SCALED_W-1:0] y;
    p = (pct > PCT_MAX) ? PCT_MAX : pct;
    x = SCALE_W'(p) * SCALE_W'(DUTY_MAX);
    y = SCALED_W'(x) * SCALED_W'(RECIP_100);
    return DUTY_W'(y >> RECIP_SHIFT);
  endfunction

endpackage

>>> rtl/smr_divider.sv
`timescale 1ns / 1ps
// Restoring divider shared by all channels: one quotient bit per cycle.
// Depends on smr_pkg for the product and quotient widths.
module smr_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [smr_pkg::PROD_W-1:0] dividend,
  input  logic [smr_pkg::LEN_W-1:0]  divisor,
  output logic                      done,
  output logic [smr_pkg::Q_W-1:0]    quotient
);
  import smr_pkg::*;

  logic              run;
  logic [QCNT_W-1:0] cnt;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsh;
  logic              fits;

  // The quotient is known to be below 2^Q_W, so the walk starts at bit Q_W-1.
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !go && run && (cnt == '0);
      if (go) begin
        run <= 1'b1;
        cnt <= QCNT_W'(Q_W - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= dividend;
      dsh      <= PROD_W'(divisor) << (Q_W - 1);
      quotient <= '0;
    end else if (run) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[Q_W-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

endmodule

>>> rtl/multichannel_speed_ramp.sv
`timescale 1ns / 1ps
// Multichannel linear speed ramp. A set-target item gives no result; the block stays idle.
// A tick stays busy while it walks the channels: a scan for each idle channel passed over
// or zero-length ramp, then scan, multiply, 8-step divide and write back for each ramping
// channel, and one closing scan; the next item goes in the cycle after. Results are
// one-cycle strobes that cannot be stalled. Reset (rst, synchronous) clears all channel
// state and sets active_channels to 4.
module multichannel_speed_ramp #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  smr_pkg::smr_req_t         request,
  output logic                      result_valid,
  output smr_pkg::smr_res_t         result,
  input  logic                      cfg_we,
  input  logic [smr_pkg::CFG_W-1:0] cfg_data
);
  import smr_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0] state;

  // Configuration register.
  logic [CFG_W-1:0] active_channels;
  logic [CNT_W-1:0] n_use;

  // Per-channel ramp state.
  logic [DUTY_W-1:0] start_duty      [NUM_CHANNELS];
  logic [DUTY_W-1:0] goal_duty       [NUM_CHANNELS];
  logic [DUTY_W-1:0] present_duty    [NUM_CHANNELS];
  logic [TIME_W-1:0] ramp_start_time [NUM_CHANNELS];
  logic [LEN_W-1:0]  ramp_length     [NUM_CHANNELS];
  logic              ramping_up      [NUM_CHANNELS];

  // Tick walk state.
  logic [NUM_CHANNELS-1:0] pending;
  logic [NUM_CHANNELS-1:0] busy_vec;
  logic [NUM_CHANNELS-1:0] idx_hot;
  logic [IDX_W-1:0]        idx;
  logic [TIME_W-1:0]       now_lat;
  logic [LEN_W-1:0]        el_c;

  // One read port into the channel state: the item's channel while idle,
  // the walk index while a tick is in progress.
  logic [IDX_W-1:0]  rd_idx;
  logic [DUTY_W-1:0] cur_start;
  logic [DUTY_W-1:0] cur_goal;
  logic [DUTY_W-1:0] cur_present;
  logic [TIME_W-1:0] cur_time;
  logic [LEN_W-1:0]  cur_len;

  logic [TIME_W-1:0] elapsed;
  logic [LEN_W-1:0]  el_clamp;
  logic              ramp_down;
  logic [DUTY_W-1:0] abs_diff;
  logic [PROD_W-1:0] product;

  logic              accept;
  logic              set_ok;
  logic [DUTY_W-1:0] new_goal;

  logic              div_go;
  logic              div_done;
  logic [Q_W-1:0]    div_q;

  logic              emit;
  logic [DUTY_W-1:0] emit_duty;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // A register value above the channel count acts as the channel count.
  always_comb begin
    if (32'(active_channels) > 32'(NUM_CHANNELS)) begin
      n_use = CNT_W'(NUM_CHANNELS);
    end else begin
      n_use = CNT_W'(active_channels);
    end
  end

  assign rd_idx      = (state == ST_IDLE) ? IDX_W'(request.channel) : idx;
  assign cur_start   = start_duty[rd_idx];
  assign cur_goal    = goal_duty[rd_idx];
  assign cur_present = present_duty[rd_idx];
  assign cur_time    = ramp_start_time[rd_idx];
  assign cur_len     = ramp_length[rd_idx];

  assign set_ok   = (32'(request.channel) < 32'(n_use));
  assign new_goal = pct_to_duty(request.speed_percent);

  // Which channels still have work, frozen when the tick is taken. A channel's
  // status only changes when the walk itself writes it, so this mask also tells
  // which write of the tick is the final one.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      busy_vec[i] = (32'(i) < 32'(n_use)) &&
                    (ramping_up[i] ? (present_duty[i] < goal_duty[i])
                                   : (present_duty[i] > goal_duty[i]));
      idx_hot[i]  = (32'(i) == 32'(idx));
    end
  end

  // Elapsed time wraps modulo 2^32 and is clamped to the ramp length.
  assign elapsed  = now_lat - cur_time;
  assign el_clamp = (elapsed > TIME_W'(cur_len)) ? cur_len : elapsed[LEN_W-1:0];

  // The division works on magnitudes; negating the quotient afterwards gives
  // truncation toward zero.
  assign ramp_down = (cur_goal < cur_start);
  assign abs_diff  = ramp_down ? (cur_start - cur_goal) : (cur_goal - cur_start);
  assign product   = PROD_W'(el_c) * PROD_W'(abs_diff);

  assign div_go = (state == ST_MUL);

  smr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (product),
    .divisor  (cur_len),
    .done     (div_done),
    .quotient (div_q)
  );

  // A duty write happens either straight from the scan (zero-length ramp jumps
  // to the goal) or when the divider finishes.
  always_comb begin
    emit      = 1'b0;
    emit_duty = cur_goal;
    unique case (state)
      ST_SCAN: begin
        emit = (pending != '0) && pending[idx] && (cur_len == '0);
      end
      ST_DIV: begin
        emit      = div_done;
        emit_duty = ramp_down ? (cur_start - div_q) : (cur_start + div_q);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer and walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      active_channels <= CFG_RESET;
      pending         <= '0;
      idx             <= '0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cfg_we) begin
        active_channels <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (request.cmd == CMD_TICK)) begin
            pending <= busy_vec;
            idx     <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pending == '0) begin
            state <= ST_IDLE;
          end else if (!pending[idx]) begin
            idx <= idx + 1'b1;
          end else if (cur_len != '0) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (emit) begin
        pending <= pending & ~idx_hot;
        idx     <= idx + 1'b1;
      end
    end
  end

  // Result payload and per-tick latches.
  always_ff @(posedge clk) begin
    if (accept && (request.cmd == CMD_TICK)) begin
      now_lat <= request.now_ms;
    end
    if (state == ST_SCAN) begin
      el_c <= el_clamp;
    end
    if (emit) begin
      result.out_channel <= CHAN_W'(idx);
      result.duty        <= emit_duty;
      result.last        <= ((pending & ~idx_hot) == '0);
    end
  end

  // Channel state: a set target writes the item's channel, a duty write the
  // walk's channel; both never happen in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_duty[i]      <= '0;
        goal_duty[i]       <= '0;
        present_duty[i]    <= '0;
        ramp_start_time[i] <= '0;
        ramp_length[i]     <= '0;
        ramping_up[i]      <= 1'b0;
      end
    end else begin
      if (accept && (request.cmd == CMD_SET) && set_ok) begin
        start_duty[rd_idx]      <= cur_present;
        goal_duty[rd_idx]       <= new_goal;
        ramp_start_time[rd_idx] <= request.now_ms;
        ramp_length[rd_idx]     <= request.ramp_ms;
        ramping_up[rd_idx]      <= (cur_present < new_goal);
      end
      if (emit) begin
        present_duty[idx] <= emit_duty;
      end
    end
  end

endmodule

>>> rtl/smr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the multichannel speed ramp, bound to the top level.
// Depends on smr_pkg for the item types and command codes.
module smr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input smr_pkg::smr_req_t         request,
  input logic                      result_valid,
  input smr_pkg::smr_res_t         result
);
  import smr_pkg::*;

  // Duty writes only come out while a tick is being walked.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe while block idle");

  // The final write of a tick ends the walk.
  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !busy)
    else $error("block still busy after final result of tick");

  // A set-target item causes no result.
  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.cmd == CMD_SET)) |=> (!result_valid && !busy))
    else $error("set target item caused activity");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("block not idle after reset");

endmodule

bind multichannel_speed_ramp smr_checker u_smr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .request      (request),
  .result_valid (result_valid),
  .result       (result)
);
